### rtl/hbbc_pkg.sv
// Package for the hashed block buffer cache.
// Holds the channel word types, the slot entry layout, opcodes and status codes.
// No dependencies.
package hbbc_pkg;

   localparam int BUCKETS_DEFAULT = 13;
   localparam int WAYS_DEFAULT    = 30;
   localparam int RANK_W          = 5;
   localparam int COUNT_W         = 8;
   localparam int BUCKET_W        = 6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   typedef enum logic [1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PIN     = 2'd2,
      OP_UNPIN   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_COUNT   = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  device_id;
      logic [31:0] block_number;
      logic [8:0]  slot_handle;
   } req_type;

   typedef struct packed {
      logic [8:0] slot_id;
      logic       hit;
      logic       needs_fill;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         dev;
      logic [31:0]        blk;
      logic               valid;
      logic [COUNT_W-1:0] count;
      logic [RANK_W-1:0]  rank;
   } entry_type;

endpackage

### rtl/hashed_block_buffer_cache.sv
// Hashed block buffer cache tag store: top level.
// Uses hbbc_pkg, hbbc_mod (bucket remainder) and hbbc_ram (slot store).
//
// One request word at a time. A get works out the block-number remainder (a
// multiply by the reciprocal of the bucket count), then the bucket base, then
// scans the bucket through the single read port of the slot store, then
// decides and posts the response word; the next request can be taken once
// the response is posted.
// Release, pin and unpin find the bucket base by repeated addition of WAYS,
// then read the slot, write the changed count back (or flag ST_COUNT) and
// post the response. A release that brings the count to zero rewrites the
// whole bucket's recency order first. After reset a clearing pass writes
// every slot, one per cycle, before the first request word is taken. A
// finished response waits in an output register; the next request is taken
// while it waits, and posting stalls only while that register still holds
// an unaccepted word.
module hashed_block_buffer_cache #(
   parameter int BUCKETS = hbbc_pkg::BUCKETS_DEFAULT,
   parameter int WAYS    = hbbc_pkg::WAYS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hbbc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hbbc_pkg::rsp_type rsp_data
);
   import hbbc_pkg::*;

   localparam int SLOTS = BUCKETS * WAYS;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(WAYS + 1);

   typedef enum logic [10:0] {
      S_CLEAR = 11'b000_0000_0001,
      S_IDLE  = 11'b000_0000_0010,
      S_GMOD  = 11'b000_0000_0100,
      S_GBASE = 11'b000_0000_1000,
      S_GSCAN = 11'b000_0001_0000,
      S_GDEC  = 11'b000_0010_0000,
      S_HBASE = 11'b000_0100_0000,
      S_HREAD = 11'b000_1000_0000,
      S_HEVAL = 11'b001_0000_0000,
      S_SWEEP = 11'b010_0000_0000,
      S_DONE  = 11'b100_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                ev_v_ff, ev_v_in;
   logic [AW-1:0]       ev_addr_ff, ev_addr_in;
   logic                hit_f_ff, hit_f_in;
   logic [AW-1:0]       hit_addr_ff, hit_addr_in;
   entry_type           hit_e_ff, hit_e_in;
   logic                free_f_ff, free_f_in;
   logic [AW-1:0]       free_addr_ff, free_addr_in;
   logic [RANK_W-1:0]   free_rank_ff, free_rank_in;
   logic [RANK_W-1:0]   swp_rank_ff, swp_rank_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [RANK_W-1:0]   clr_way_ff, clr_way_in;

   logic                mod_start, mod_done;
   logic [BUCKET_W-1:0] mod_rem;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   entry_type           ram_wdata, ram_rdata;
   logic [AW-1:0]       handle_addr, issue_addr;

   hbbc_mod #(.BUCKETS(BUCKETS)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .value (req_ff.block_number),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   hbbc_ram #(.WIDTH($bits(entry_type)), .DEPTH(SLOTS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign handle_addr = AW'(req_ff.slot_handle);
   assign issue_addr  = base_ff + AW'(cnt_ff);
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      ev_v_in      = 1'b0;
      ev_addr_in   = ev_addr_ff;
      hit_f_in     = hit_f_ff;
      hit_addr_in  = hit_addr_ff;
      hit_e_in     = hit_e_ff;
      free_f_in    = free_f_ff;
      free_addr_in = free_addr_ff;
      free_rank_in = free_rank_ff;
      swp_rank_in  = swp_rank_ff;
      clr_addr_in  = clr_addr_ff;
      clr_way_in   = clr_way_ff;
      mod_start    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = handle_addr;
      ram_wdata    = ram_rdata;
      ram_raddr    = issue_addr;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we         = 1'b1;
            ram_waddr      = clr_addr_ff;
            ram_wdata      = '0;
            ram_wdata.rank = RANK_W'(WAYS - 1) - clr_way_ff;
            clr_addr_in    = clr_addr_ff + AW'(1);
            clr_way_in     = (clr_way_ff == RANK_W'(WAYS - 1)) ? '0
                                                             : clr_way_ff + RANK_W'(1);
            if (clr_addr_ff == AW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in            = req_data;
               res_in            = '0;
               res_in.slot_id    = req_data.slot_handle;
               res_in.status     = ST_OK;
               hit_f_in          = 1'b0;
               free_f_in         = 1'b0;
               cnt_in            = '0;
               base_in           = '0;
               if (req_data.opcode == OP_GET) begin
                  state_in = S_GMOD;
               end else if (32'(req_data.slot_handle) >= 32'(SLOTS)) begin
                  res_in.status = ST_COUNT;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_HBASE;
               end
            end
         end
         S_GMOD: begin
            // start pulses once on entry here, then this state waits for done
            mod_start = (cnt_ff == '0) && !ev_v_ff;
            ev_v_in   = 1'b1;
            if (mod_done) begin
               ev_v_in  = 1'b0;
               state_in = S_GBASE;
            end
         end
         S_GBASE: begin
            base_in  = AW'(32'(mod_rem) * 32'(WAYS));
            cnt_in   = '0;
            state_in = S_GSCAN;
         end
         S_GSCAN: begin
            if (cnt_ff < CW'(WAYS)) begin
               ev_v_in    = 1'b1;
               ev_addr_in = issue_addr;
               cnt_in     = cnt_ff + CW'(1);
            end
            if (ev_v_ff) begin
               // hit keeps the most recent match, free the least recent idle slot
               if (ram_rdata.dev == req_ff.device_id &&
                   ram_rdata.blk == req_ff.block_number &&
                   (!hit_f_ff || ram_rdata.rank < hit_e_ff.rank)) begin
                  hit_f_in    = 1'b1;
                  hit_addr_in = ev_addr_ff;
                  hit_e_in    = ram_rdata;
               end
               if (ram_rdata.count == '0 &&
                   (!free_f_ff || ram_rdata.rank > free_rank_ff)) begin
                  free_f_in    = 1'b1;
                  free_addr_in = ev_addr_ff;
                  free_rank_in = ram_rdata.rank;
               end
               if (cnt_ff == CW'(WAYS)) begin
                  state_in = S_GDEC;
               end
            end
         end
         S_GDEC: begin
            state_in = S_DONE;
            if (hit_f_ff) begin
               res_in.slot_id = 9'(hit_addr_ff);
               res_in.hit     = 1'b1;
               if (hit_e_ff.count == COUNT_MAX) begin
                  res_in.status = ST_COUNT;
               end else begin
                  res_in.needs_fill = !hit_e_ff.valid;
                  ram_we            = 1'b1;
                  ram_waddr         = hit_addr_ff;
                  ram_wdata         = hit_e_ff;
                  ram_wdata.valid   = 1'b1;
                  ram_wdata.count   = hit_e_ff.count + COUNT_W'(1);
               end
            end else if (free_f_ff) begin
               res_in.slot_id    = 9'(free_addr_ff);
               res_in.needs_fill = 1'b1;
               ram_we            = 1'b1;
               ram_waddr         = free_addr_ff;
               ram_wdata.dev     = req_ff.device_id;
               ram_wdata.blk     = req_ff.block_number;
               ram_wdata.valid   = 1'b1;
               ram_wdata.count   = COUNT_W'(1);
               ram_wdata.rank    = free_rank_ff;
            end else begin
               res_in.slot_id = '0;
               res_in.status  = ST_NO_FREE;
            end
         end
         S_HBASE: begin
            if (32'(req_ff.slot_handle) >= 32'(base_ff) + 32'(WAYS)) begin
               base_in = base_ff + AW'(WAYS);
            end else begin
               state_in = S_HREAD;
            end
         end
         S_HREAD: begin
            ram_raddr = handle_addr;
            state_in  = S_HEVAL;
         end
         S_HEVAL: begin
            state_in = S_DONE;
            if (req_ff.opcode == OP_PIN) begin
               if (ram_rdata.count == COUNT_MAX) begin
                  res_in.status = ST_COUNT;
               end else begin
                  ram_we          = 1'b1;
                  ram_wdata.count = ram_rdata.count + COUNT_W'(1);
               end
            end else if (ram_rdata.count == '0) begin
               res_in.status = ST_COUNT;
            end else if (req_ff.opcode == OP_RELEASE && ram_rdata.count == COUNT_W'(1)) begin
               swp_rank_in = ram_rdata.rank;
               cnt_in      = '0;
               state_in    = S_SWEEP;
            end else begin
               ram_we          = 1'b1;
               ram_wdata.count = ram_rdata.count - COUNT_W'(1);
            end
         end
         S_SWEEP: begin
            if (cnt_ff < CW'(WAYS)) begin
               ev_v_in    = 1'b1;
               ev_addr_in = issue_addr;
               cnt_in     = cnt_ff + CW'(1);
            end
            if (ev_v_ff) begin
               ram_we    = 1'b1;
               ram_waddr = ev_addr_ff;
               if (ev_addr_ff == handle_addr) begin
                  ram_wdata.count = '0;
                  ram_wdata.rank  = '0;
               end else if (ram_rdata.rank < swp_rank_ff) begin
                  ram_wdata.rank = ram_rdata.rank + RANK_W'(1);
               end
               if (cnt_ff == CW'(WAYS)) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         ev_v_ff      <= 1'b0;
         clr_addr_ff  <= '0;
         clr_way_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ev_v_ff      <= ev_v_in;
         clr_addr_ff  <= clr_addr_in;
         clr_way_ff   <= clr_way_in;
      end
      req_ff       <= req_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      base_ff      <= base_in;
      cnt_ff       <= cnt_in;
      ev_addr_ff   <= ev_addr_in;
      hit_f_ff     <= hit_f_in;
      hit_addr_ff  <= hit_addr_in;
      hit_e_ff     <= hit_e_in;
      free_f_ff    <= free_f_in;
      free_addr_ff <= free_addr_in;
      free_rank_ff <= free_rank_in;
      swp_rank_ff  <= swp_rank_in;
   end

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !ram_we)
      else $error("slot store written outside a request");
   a_get_slot_in_bucket: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GDEC && (hit_f_ff || free_f_ff)) |->
         (res_in.slot_id >= 9'(base_ff) && 32'(res_in.slot_id) < 32'(base_ff) + 32'(WAYS)))
      else $error("get picked a slot outside its bucket");
   a_handle_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HREAD) |->
         (handle_addr >= base_ff && 32'(handle_addr) < 32'(base_ff) + 32'(WAYS)))
      else $error("bucket base of handle wrong");
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished response not posted");
endmodule

### rtl/hbbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

### rtl/hbbc_mod.sv
// Remainder of a 32-bit block number by the bucket count, by multiplying with
// a rounded-up reciprocal. Uses hbbc_pkg. Done pulses once the remainder is registered.
module hbbc_mod #(
   parameter int BUCKETS = hbbc_pkg::BUCKETS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   value,
   output logic                          done,
   output logic [hbbc_pkg::BUCKET_W-1:0] rem
);
   import hbbc_pkg::*;

   // quotient = (x * ceil(2^(32+l) / d)) >> (32+l), l = ceil(log2 d): exact for any 32-bit x
   localparam int          SHIFT = 32 + $clog2(BUCKETS);
   localparam logic [32:0] RECIP =
      33'(((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                step_ff, step_in;
   logic [31:0]         val_ff, val_in;
   logic [64:0]         prod_ff, prod_in;
   logic [BUCKET_W-1:0] rem_ff, rem_in;
   logic [31:0]         quot;
   logic [31:0]         diff;

   always_comb begin
      quot    = 32'(prod_ff >> SHIFT);
      diff    = val_ff - quot * 32'(BUCKETS);
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      val_in  = val_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 1'b0;
         val_in  = value;
      end else if (busy_ff) begin
         if (!step_ff) begin
            prod_in = 65'(val_ff) * 65'(RECIP);
            step_in = 1'b1;
         end else begin
            rem_in  = BUCKET_W'(diff);
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      val_ff  <= val_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < BUCKET_W'(BUCKETS)))
      else $error("bucket remainder out of range");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("remainder done held longer than one cycle");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff)
      else $error("remainder done while still busy");
endmodule
